// ----- src/mcspe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-case sort program executor package
// Item types, operation and status codes, and the permutation table that
// seeds registers x1..x3 of every test case.
// ----------------------------------------------------------------------------
package mcspe_pkg;

    localparam int NUM_CASES   = 6;
    localparam int REG_FIELD_W = 3;
    localparam int WORD_W      = 32;
    localparam int NUM_TARGETS = NUM_CASES * 3;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_AND  = 3'd2;
    localparam logic [2:0] OP_SLT  = 3'd3;
    localparam logic [2:0] OP_CMOV = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_OP = 2'd1;
    localparam logic [1:0] ST_LIMIT  = 2'd2;

    localparam logic ACT_EXEC    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    localparam logic [1:0] PERM_TABLE [NUM_CASES][3] = '{
        '{2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd3, 2'd2},
        '{2'd2, 2'd1, 2'd3},
        '{2'd2, 2'd3, 2'd1},
        '{2'd3, 2'd1, 2'd2},
        '{2'd3, 2'd2, 2'd1}
    };

    typedef struct packed {
        logic       action;
        logic [2:0] opcode;
        logic [2:0] dest_reg;
        logic [2:0] src_a;
        logic [2:0] src_b;
        logic [2:0] src_cond;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] steps_done;
        logic       at_limit;
        logic       all_sorted;
        logic [4:0] correct_positions;
    } result_t;

    function automatic logic [WORD_W-1:0] reset_value(input int c, input int r);
        logic [WORD_W-1:0] v;
        v = '0;
        if (r >= 1 && r <= 3)
        begin
            v = WORD_W'(PERM_TABLE[c][r-1]);
        end
        return v;
    endfunction

endpackage

// ----- src/multi_case_sort_program_executor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-case sort program executor
// Runs one instruction stream over six test cases with a flop register file.
// ----------------------------------------------------------------------------
// The block accepts one item per cycle while the result is not stalled and
// presents its result from a result register: an input register holds the
// item, then the six lane ALUs read the register file, write it back and
// capture the result register in the same cycle. Back-to-back instructions
// see each other's writes since the register file updates at the end of that
// cycle. Restart reloads all cases at once, so there is no clearing pass.
module multi_case_sort_program_executor_top
    import mcspe_pkg::*;
#(
    parameter int NUM_REGISTERS = 8,
    parameter int STEP_LIMIT    = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int IDX_W = $clog2(NUM_REGISTERS);
    localparam int EXT_W = IDX_W + REG_FIELD_W;

    logic [WORD_W-1:0] rf_reg  [NUM_CASES][NUM_REGISTERS];
    logic [WORD_W-1:0] rf_next [NUM_CASES][NUM_REGISTERS];
    logic [WORD_W-1:0] lane_res [NUM_CASES];

    logic              item_valid_reg;
    item_t             item_reg;
    logic [5:0]        step_reg;
    logic [5:0]        step_next;
    logic              result_valid_reg;
    logic [1:0]        status_reg;
    logic [5:0]        steps_reg;
    logic              at_limit_reg;
    logic [NUM_TARGETS-1:0] ok_reg;
    logic [NUM_TARGETS-1:0] ok_next;

    logic              take;
    logic              exec_fire;
    logic [EXT_W-1:0]  ext_d, ext_a, ext_b, ext_c;
    logic [IDX_W-1:0]  d_idx, a_idx, b_idx, c_idx;
    logic              regs_ok;
    logic              op_ok;
    logic              below_limit;
    logic              do_step;
    logic [1:0]        status_next;
    logic [4:0]        correct_cnt;
    logic              x0_any;

    assign exec_fire  = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !exec_fire;
    assign take       = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (exec_fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    assign ext_d = {{IDX_W{1'b0}}, item_reg.dest_reg};
    assign ext_a = {{IDX_W{1'b0}}, item_reg.src_a};
    assign ext_b = {{IDX_W{1'b0}}, item_reg.src_b};
    assign ext_c = {{IDX_W{1'b0}}, item_reg.src_cond};
    assign d_idx = ext_d[IDX_W-1:0];
    assign a_idx = ext_a[IDX_W-1:0];
    assign b_idx = ext_b[IDX_W-1:0];
    assign c_idx = ext_c[IDX_W-1:0];

    assign regs_ok = (ext_d < EXT_W'(NUM_REGISTERS)) && (ext_a < EXT_W'(NUM_REGISTERS))
                  && (ext_b < EXT_W'(NUM_REGISTERS)) && (ext_c < EXT_W'(NUM_REGISTERS));
    assign op_ok       = (item_reg.opcode <= OP_CMOV);
    assign below_limit = (step_reg < 6'(STEP_LIMIT));
    assign do_step     = (item_reg.action == ACT_EXEC) && op_ok && regs_ok && below_limit;

    always_comb
    begin
        if (item_reg.action == ACT_RESTART)
        begin
            status_next = ST_OK;
        end
        else if (!(op_ok && regs_ok))
        begin
            status_next = ST_BAD_OP;
        end
        else if (!below_limit)
        begin
            status_next = ST_LIMIT;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    always_comb
    begin
        if (item_reg.action == ACT_RESTART)
        begin
            step_next = '0;
        end
        else if (do_step)
        begin
            step_next = step_reg + 6'd1;
        end
        else
        begin
            step_next = step_reg;
        end
    end

    for (genvar g = 0; g < NUM_CASES; g++)
    begin : g_lane
        mcspe_lane u_lane (
            .opcode (item_reg.opcode),
            .a      (rf_reg[g][a_idx]),
            .b      (rf_reg[g][b_idx]),
            .cond   (rf_reg[g][c_idx]),
            .result (lane_res[g])
        );
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CASES; c++)
        begin
            for (int r = 0; r < NUM_REGISTERS; r++)
            begin
                if (item_reg.action == ACT_RESTART)
                begin
                    rf_next[c][r] = reset_value(c, r);
                end
                else if (do_step && r != 0 && d_idx == IDX_W'(r))
                begin
                    rf_next[c][r] = lane_res[c];
                end
                else
                begin
                    rf_next[c][r] = rf_reg[c][r];
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CASES; c++)
        begin
            for (int p = 0; p < 3; p++)
            begin
                ok_next[c*3+p] = (rf_next[c][p+1] == WORD_W'(p + 1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CASES; c++)
            begin
                for (int r = 0; r < NUM_REGISTERS; r++)
                begin
                    rf_reg[c][r] <= reset_value(c, r);
                end
            end
            step_reg <= '0;
        end
        else if (exec_fire)
        begin
            rf_reg   <= rf_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            status_reg   <= status_next;
            steps_reg    <= step_next;
            at_limit_reg <= (step_next >= 6'(STEP_LIMIT));
            ok_reg       <= ok_next;
        end
    end

    always_comb
    begin
        correct_cnt = '0;
        for (int i = 0; i < NUM_TARGETS; i++)
        begin
            correct_cnt = correct_cnt + 5'(ok_reg[i]);
        end
    end

    assign result_valid             = result_valid_reg;
    assign result.status            = status_reg;
    assign result.steps_done        = steps_reg;
    assign result.at_limit          = at_limit_reg;
    assign result.all_sorted        = &ok_reg;
    assign result.correct_positions = correct_cnt;

    always_comb
    begin
        x0_any = 1'b0;
        for (int c = 0; c < NUM_CASES; c++)
        begin
            x0_any = x0_any | (|rf_reg[c][0]);
        end
    end

    // The step count never runs past the limit.
    assert property (@(posedge clk) disable iff (!rst_n) step_reg <= 6'(STEP_LIMIT))
        else $error("step count exceeded the limit");

    // Register x0 of every case reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n) !x0_any)
        else $error("x0 was written");

    // An executed instruction advances the step count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && do_step |=> step_reg == $past(step_reg) + 6'd1)
        else $error("step count did not advance");

    // A restart reloads the permutations, which place six values correctly.
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && item_reg.action == ACT_RESTART
        |=> result_valid && result.correct_positions == 5'd6 && step_reg == 6'd0)
        else $error("restart did not reload the cases");

endmodule

// ----- src/mcspe_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Executor lane ALU
// Computes ADD, SUB, AND, signed SLT and CMOV on one test case's operands.
// ----------------------------------------------------------------------------
module mcspe_lane
    import mcspe_pkg::*;
(
    input  logic [2:0]        opcode,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    input  logic [WORD_W-1:0] cond,
    output logic [WORD_W-1:0] result
);

    always_comb
    begin
        case (opcode)
            OP_ADD:  result = a + b;
            OP_SUB:  result = a - b;
            OP_AND:  result = a & b;
            OP_SLT:  result = {{(WORD_W-1){1'b0}}, ($signed(a) < $signed(b))};
            OP_CMOV: result = (cond != '0) ? a : b;
            default: result = b;
        endcase
    end

endmodule

// ----- sim/multi_case_sort_program_executor_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-case sort program executor testbench
// Drives restart and instruction items into the executor and checks every
// result transfer against a cycle-free model of the six test cases kept in
// the bench. A directed program sorts all cases and runs into the step limit,
// then random episodes follow. Both sides idle and stall at random, the
// receiver once holds off long enough to back up the input, and the sender
// once waits until every outstanding result has arrived.
// ----------------------------------------------------------------------------
module multi_case_sort_program_executor_top_tb;
    import mcspe_pkg::*;

    localparam int REG_COUNT      = 8;
    localparam int STEP_MAX       = 16;
    localparam int ITEM_TARGET    = 950;
    localparam int DRAIN_POINT    = 475;
    localparam int LONG_HOLD      = 120;
    localparam int HOLD_TRIGGER   = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 10;

    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    logic [WORD_W-1:0] lane_regs [NUM_CASES][REG_COUNT];
    logic [5:0]        step_count;

    item_t   pending_items[$];
    result_t expected_results[$];

    int  planned_items    = 0;
    int  error_count      = 0;
    int  results_seen     = 0;
    int  send_gap         = 0;
    int  hold_left        = 0;
    int  idle_cycles      = 0;
    bit  tx_steady        = 1'b0;
    bit  rx_steady        = 1'b0;
    bit  long_hold_done   = 1'b0;

    multi_case_sort_program_executor_top #(
        .NUM_REGISTERS(REG_COUNT),
        .STEP_LIMIT   (STEP_MAX)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    always #6 clk = ~clk;

    function automatic void load_cases();
        for (int c = 0; c < NUM_CASES; c++)
        begin
            for (int r = 0; r < REG_COUNT; r++)
            begin
                lane_regs[c][r] = '0;
            end
            for (int r = 0; r < 3; r++)
            begin
                lane_regs[c][r + 1] = WORD_W'(PERM_TABLE[c][r]);
            end
        end
        step_count = '0;
    endfunction

    function automatic result_t execute_item(input item_t it);
        result_t           res;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] cnd;
        logic [WORD_W-1:0] r;
        int                hits;
        bit                sorted;
        res    = '0;
        hits   = 0;
        sorted = 1'b1;
        if (it.action == ACT_RESTART)
        begin
            load_cases();
        end
        else if (it.opcode > OP_CMOV)
        begin
            res.status = ST_BAD_OP;
        end
        else if (step_count >= STEP_MAX)
        begin
            res.status = ST_LIMIT;
        end
        else
        begin
            step_count = step_count + 6'd1;
            if (it.dest_reg != '0)
            begin
                for (int c = 0; c < NUM_CASES; c++)
                begin
                    a   = lane_regs[c][it.src_a];
                    b   = lane_regs[c][it.src_b];
                    cnd = lane_regs[c][it.src_cond];
                    case (it.opcode)
                        OP_ADD:  r = a + b;
                        OP_SUB:  r = a - b;
                        OP_AND:  r = a & b;
                        OP_SLT:  r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                        default: r = (cnd != '0) ? a : b;
                    endcase
                    lane_regs[c][it.dest_reg] = r;
                end
            end
        end
        for (int c = 0; c < NUM_CASES; c++)
        begin
            for (int r = 1; r <= 3; r++)
            begin
                if (lane_regs[c][r] == WORD_W'(r))
                begin
                    hits++;
                end
                else
                begin
                    sorted = 1'b0;
                end
            end
        end
        res.steps_done        = step_count;
        res.at_limit          = (step_count >= STEP_MAX);
        res.all_sorted        = sorted;
        res.correct_positions = 5'(hits);
        return res;
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return 0;
        end
        else if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0t] result %0d: %s is %0d, expected %0d",
                 $time, results_seen, field, got, want);
        error_count++;
    endtask

    task automatic check_result(input result_t got, input result_t want);
        if (got.status != want.status)
        begin
            report_mismatch("status", int'(got.status), int'(want.status));
        end
        if (got.steps_done != want.steps_done)
        begin
            report_mismatch("steps_done", int'(got.steps_done), int'(want.steps_done));
        end
        if (got.at_limit != want.at_limit)
        begin
            report_mismatch("at_limit", int'(got.at_limit), int'(want.at_limit));
        end
        if (got.all_sorted != want.all_sorted)
        begin
            report_mismatch("all_sorted", int'(got.all_sorted), int'(want.all_sorted));
        end
        if (got.correct_positions != want.correct_positions)
        begin
            report_mismatch("correct_positions", int'(got.correct_positions),
                            int'(want.correct_positions));
        end
    endtask

    task automatic push_instr(input logic [2:0] op, input logic [2:0] rd,
                              input logic [2:0] ra, input logic [2:0] rb,
                              input logic [2:0] rc);
        item_t it;
        it.action   = ACT_EXEC;
        it.opcode   = op;
        it.dest_reg = rd;
        it.src_a    = ra;
        it.src_b    = rb;
        it.src_cond = rc;
        pending_items = {pending_items, it};
        planned_items++;
    endtask

    task automatic push_restart();
        item_t it;
        it        = item_t'(16'($urandom));
        it.action = ACT_RESTART;
        pending_items = {pending_items, it};
        planned_items++;
    endtask

    // Orders x[lo] and x[hi] through scratch registers x4..x6.
    task automatic push_compare_swap(input logic [2:0] lo, input logic [2:0] hi);
        push_instr(OP_SLT,  3'd4, hi,   lo,   3'd0);
        push_instr(OP_CMOV, 3'd5, hi,   lo,   3'd4);
        push_instr(OP_CMOV, 3'd6, lo,   hi,   3'd4);
        push_instr(OP_ADD,  lo,   3'd5, 3'd0, 3'd0);
        push_instr(OP_ADD,  hi,   3'd6, 3'd0, 3'd0);
    endtask

    task automatic push_episode();
        int          len;
        logic [2:0]  op;
        push_restart();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24) : $urandom_range(3, 16);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
            end
            else
            begin
                op = 3'($urandom_range(OP_ADD, OP_CMOV));
            end
            push_instr(op, 3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (results_seen < planned_items)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (!item_valid || !item_stall)
            begin
                if (item_valid)
                begin
                    expected_results = {expected_results, execute_item(item)};
                    send_gap = pick_gap(tx_steady);
                end
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
            if ($urandom_range(0, 63) == 0)
            begin
                tx_steady = !tx_steady;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("[%0t] result transfer with no item outstanding", $time);
                    error_count++;
                end
                else
                begin
                    check_result(result, expected_results.pop_front());
                end
                results_seen++;
            end
            if (!long_hold_done && results_seen >= HOLD_TRIGGER)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            else if (hold_left == 0 && !result_stall)
            begin
                hold_left = pick_gap(rx_steady);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
            if ($urandom_range(0, 63) == 0)
            begin
                rx_steady = !rx_steady;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] no transfer for %0d cycles", $time, idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        load_cases();

        // Sort every case with three compare-swaps, then run into the limit.
        push_restart();
        push_compare_swap(3'd1, 3'd2);
        push_compare_swap(3'd2, 3'd3);
        push_compare_swap(3'd1, 3'd2);
        push_instr(OP_ADD,   3'd0, 3'd1, 3'd2, 3'd0);
        push_instr(OP_SUB,   3'd7, 3'd1, 3'd2, 3'd0);
        push_instr(OP_RSVD7, 3'd7, 3'd7, 3'd7, 3'd7);

        // Wrapping arithmetic, signed compare and a false condition.
        push_restart();
        push_instr(OP_SUB,   3'd4, 3'd0, 3'd3, 3'd0);
        push_instr(OP_ADD,   3'd5, 3'd4, 3'd3, 3'd0);
        push_instr(OP_AND,   3'd6, 3'd4, 3'd2, 3'd0);
        push_instr(OP_SLT,   3'd7, 3'd4, 3'd1, 3'd0);
        push_instr(OP_SLT,   3'd7, 3'd1, 3'd4, 3'd0);
        push_instr(OP_CMOV,  3'd1, 3'd2, 3'd3, 3'd0);
        push_instr(OP_RSVD5, 3'd1, 3'd1, 3'd1, 3'd1);
        push_instr(OP_RSVD6, 3'd2, 3'd3, 3'd4, 3'd5);

        while (planned_items < DRAIN_POINT)
        begin
            push_episode();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        while (planned_items < ITEM_TARGET)
        begin
            push_episode();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
